[rtl/qalu_pkg.sv]
// Shared types, opcodes and a saturation helper for the quaternion ALU.
package qalu_pkg;

  typedef enum logic [2:0] {
    OP_QMUL  = 3'd0,
    OP_QMULV = 3'd1,
    OP_SCALE = 3'd2,
    OP_DIV   = 3'd3,
    OP_NORM  = 3'd4,
    OP_CONJ  = 3'd5,
    OP_LEN   = 3'd6,
    OP_CMP   = 3'd7
  } op_t;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // Sideband that travels with an item through the pipeline.
  typedef struct packed {
    op_t              op;
    logic [3:0][31:0] q;
    logic [31:0]      s;
    logic             eq;
  } qalu_ctl_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] res;
    if (v > 66'sd2147483647) begin
      res = S32_MAX;
    end else if (v < -66'sd2147483648) begin
      res = S32_MIN;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

[rtl/qalu_in_if.sv]
// Input channel interface of the quaternion ALU.
interface qalu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] a_w;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] b_w;
  logic signed [31:0] scalar;

  modport source(output valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar,
                 input ready);
  modport sink(input valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar,
               output ready);
endinterface

[rtl/qalu_out_if.sv]
// Result channel interface of the quaternion ALU.
interface qalu_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_z;
  logic signed [31:0] r_w;
  logic [31:0] magnitude;
  logic        is_equal;
  logic        error;

  modport source(output valid, r_x, r_y, r_z, r_w, magnitude, is_equal, error,
                 input ready);
  modport sink(input valid, r_x, r_y, r_z, r_w, magnitude, is_equal, error,
               output ready);
endinterface

[rtl/qalu_mul.sv]
// Front end: component products, product sums with saturation, conjugate, sum of squares.
module qalu_mul import qalu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  op_t              in_op,
  input  logic [3:0][31:0] in_a,
  input  logic [3:0][31:0] in_b,
  input  logic [31:0]      in_s,
  output logic             out_vld,
  output qalu_ctl_t        out_ctl,
  output logic [63:0]      out_sumsq
);

  logic [3:0][31:0]   bm;
  logic signed [63:0] p_nxt [4][4];
  logic [63:0]        sq_nxt [4];
  logic               eq_nxt;

  logic               v1_r, v2_r;
  op_t                op1_r, op2_r;
  logic signed [63:0] p1_r [4][4];
  logic [63:0]        sq1_r [4];
  logic [3:0][31:0]   a1_r, a2_r;
  logic [31:0]        s1_r, s2_r;
  logic               eq1_r, eq2_r;

  logic signed [65:0] f [4][4];
  logic signed [65:0] h_nxt [4][2];
  logic [63:0]        sqh_nxt [2];
  logic signed [65:0] h2_r [4][2];
  logic [63:0]        sqh2_r [2];

  logic signed [65:0] t [4];
  logic [64:0]        ssum;
  qalu_ctl_t          ctl_nxt;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (in_op == OP_SCALE) begin
        bm[j] = in_s;
      end else if (in_op == OP_QMULV && j == 3) begin
        bm[j] = '0;
      end else begin
        bm[j] = in_b[j];
      end
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p_nxt[i][j] = 64'($signed(in_a[i])) * 64'($signed(bm[j]));
      end
      sq_nxt[i] = $unsigned(64'($signed(in_a[i])) * 64'($signed(in_a[i])));
    end
    eq_nxt = (in_op == OP_CMP) && (in_a == in_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      out_vld <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_op;
      p1_r  <= p_nxt;
      sq1_r <= sq_nxt;
      a1_r  <= in_a;
      s1_r  <= in_s;
      eq1_r <= eq_nxt;
    end
  end

  // The arithmetic shift of a signed product floors toward minus infinity.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        f[i][j] = 66'(p1_r[i][j] >>> FRAC_BITS);
      end
    end
    if (op1_r == OP_SCALE) begin
      for (int i = 0; i < 4; i++) begin
        h_nxt[i][0] = f[i][i];
        h_nxt[i][1] = '0;
      end
    end else begin
      h_nxt[0][0] = f[0][3] + f[3][0];
      h_nxt[0][1] = f[1][2] - f[2][1];
      h_nxt[1][0] = f[1][3] + f[3][1];
      h_nxt[1][1] = f[2][0] - f[0][2];
      h_nxt[2][0] = f[2][3] + f[3][2];
      h_nxt[2][1] = f[0][1] - f[1][0];
      h_nxt[3][0] = f[3][3] - f[0][0];
      h_nxt[3][1] = -f[1][1] - f[2][2];
    end
    sqh_nxt[0] = sq1_r[0] + sq1_r[1];
    sqh_nxt[1] = sq1_r[2] + sq1_r[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r  <= op1_r;
      h2_r   <= h_nxt;
      sqh2_r <= sqh_nxt;
      a2_r   <= a1_r;
      s2_r   <= s1_r;
      eq2_r  <= eq1_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t[i] = h2_r[i][0] + h2_r[i][1];
    end
    ssum = {1'b0, sqh2_r[0]} + {1'b0, sqh2_r[1]};
    ctl_nxt.op = op2_r;
    ctl_nxt.s  = s2_r;
    ctl_nxt.eq = eq2_r;
    unique case (op2_r)
      OP_QMUL, OP_QMULV, OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          ctl_nxt.q[i] = sat32(t[i]);
        end
      end
      OP_CONJ: begin
        for (int i = 0; i < 3; i++) begin
          ctl_nxt.q[i] = (a2_r[i] == S32_MIN) ? S32_MAX : -a2_r[i];
        end
        ctl_nxt.q[3] = a2_r[3];
      end
      default: begin
        ctl_nxt.q = a2_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl   <= ctl_nxt;
      out_sumsq <= ssum[64] ? '1 : ssum[63:0];
    end
  end

endmodule

[rtl/qalu_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module qalu_sqrt import qalu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  qalu_ctl_t   in_ctl,
  input  logic [63:0] in_sumsq,
  output logic        out_vld,
  output qalu_ctl_t   out_ctl,
  output logic [31:0] out_root
);

  localparam int NS = 32;

  logic [65:0] rem_r  [NS-1];
  logic [31:0] root_r [NS];
  logic        v_r    [NS];
  qalu_ctl_t   c_r    [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int I = NS - 1 - k;
    logic [65:0] rin;
    logic [31:0] oin;
    logic        vin;
    qalu_ctl_t   cin;
    logic [65:0] trial;
    logic        take;

    if (k == 0) begin : g_first
      assign rin = {2'b00, in_sumsq};
      assign oin = '0;
      assign vin = in_vld;
      assign cin = in_ctl;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign oin = root_r[k-1];
      assign vin = v_r[k-1];
      assign cin = c_r[k-1];
    end

    assign trial = (66'(oin) << (I + 1)) + (66'd1 << (2 * I));
    assign take  = (rin >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= take ? (oin | (32'd1 << I)) : oin;
        c_r[k]    <= cin;
      end
    end

    if (k < NS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? (rin - trial) : rin;
        end
      end
    end
  end

  assign out_vld  = v_r[NS-1];
  assign out_ctl  = c_r[NS-1];
  assign out_root = root_r[NS-1];

endmodule

[rtl/qalu_div.sv]
// Pipelined four-lane restoring divider and the result selection stage.
module qalu_div import qalu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  qalu_ctl_t        in_ctl,
  input  logic [31:0]      in_root,
  output logic             out_vld,
  output logic [3:0][31:0] out_r,
  output logic [31:0]      out_mag,
  output logic             out_eq,
  output logic             out_err
);

  localparam int NS = 32;

  typedef struct packed {
    op_t              op;
    logic [3:0][31:0] q;
    logic             eq;
    logic [31:0]      root;
    logic [31:0]      d;
    logic             zero;
    logic [3:0]       ovf;
    logic [3:0]       neg;
  } dctl_t;

  dctl_t            c_nxt;
  logic [3:0][63:0] n_nxt;
  logic [31:0]      amag;

  logic [3:0][63:0] rem_r [NS];
  logic [3:0][31:0] quo_r [NS];
  dctl_t            c_r   [NS+1];
  logic             v_r   [NS+1];

  always_comb begin
    c_nxt.op   = in_ctl.op;
    c_nxt.q    = in_ctl.q;
    c_nxt.eq   = in_ctl.eq;
    c_nxt.root = in_root;
    if (in_ctl.op == OP_DIV) begin
      c_nxt.d = in_ctl.s[31] ? -in_ctl.s : in_ctl.s;
    end else begin
      c_nxt.d = in_root;
    end
    c_nxt.zero = (c_nxt.d == '0);
    for (int i = 0; i < 4; i++) begin
      amag        = in_ctl.q[i][31] ? -in_ctl.q[i] : in_ctl.q[i];
      n_nxt[i]    = 64'(amag) << FRAC_BITS;
      c_nxt.ovf[i] = (n_nxt[i] >= {c_nxt.d, 32'd0});
      c_nxt.neg[i] = in_ctl.q[i][31] ^ ((in_ctl.op == OP_DIV) & in_ctl.s[31]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0]   <= c_nxt;
      rem_r[0] <= n_nxt;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_stage
    localparam int I = NS - k;
    logic [63:0]      dsh;
    logic [3:0][31:0] qin;
    logic [3:0][63:0] rem_nxt;
    logic [3:0][31:0] quo_nxt;

    if (k == 1) begin : g_first
      assign qin = '0;
    end else begin : g_next
      assign qin = quo_r[k-2];
    end

    assign dsh = 64'(c_r[k-1].d) << I;

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        if (rem_r[k-1][i] >= dsh) begin
          rem_nxt[i] = rem_r[k-1][i] - dsh;
          quo_nxt[i] = qin[i] | (32'd1 << I);
        end else begin
          rem_nxt[i] = rem_r[k-1][i];
          quo_nxt[i] = qin[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_r[k]     <= c_r[k-1];
        quo_r[k-1] <= quo_nxt;
      end
    end

    if (k < NS) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
        end
      end
    end
  end

  dctl_t            cf;
  logic [3:0][31:0] quo;
  logic [3:0][31:0] dres;
  logic [3:0][31:0] r_nxt;
  logic [31:0]      mag_nxt;
  logic             eq_nxt;
  logic             err_nxt;

  assign cf  = c_r[NS];
  assign quo = quo_r[NS-1];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (cf.ovf[i]) begin
        dres[i] = cf.neg[i] ? S32_MIN : S32_MAX;
      end else if (cf.neg[i]) begin
        dres[i] = (quo[i] > S32_MIN) ? S32_MIN : -quo[i];
      end else begin
        dres[i] = quo[i][31] ? S32_MAX : quo[i];
      end
    end
    r_nxt   = '0;
    mag_nxt = '0;
    eq_nxt  = 1'b0;
    err_nxt = 1'b0;
    unique case (cf.op)
      OP_QMUL, OP_QMULV, OP_SCALE, OP_CONJ: begin
        r_nxt = cf.q;
      end
      OP_DIV, OP_NORM: begin
        err_nxt = cf.zero;
        r_nxt   = cf.zero ? '0 : dres;
      end
      OP_LEN: begin
        mag_nxt = cf.root;
      end
      OP_CMP: begin
        eq_nxt = cf.eq;
      end
      default: begin
        r_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r   <= r_nxt;
      out_mag <= mag_nxt;
      out_eq  <= eq_nxt;
      out_err <= err_nxt;
    end
  end

endmodule

[rtl/quaternion_alu_unit.sv]
// Top level of the pipelined quaternion ALU.
//
//   channel  direction  transfer carries
//   in_ch    sink       opcode, quaternion A, operand B, scalar
//   out_ch   source     r_x..r_w, magnitude, is_equal, error
//
// One item enters per cycle while no result waits untaken at the output. Its
// result passes three multiply and sum stages, 32 square root stages, one
// divider setup stage, 32 divider stages and the output register. The square
// root and divider chains, one result bit per stage, make up most of the depth.
// Reset is synchronous and clears only the valid bits of the stages.
// A result that waits at the output holds every stage, so in_ch.ready is low
// exactly while out_ch holds a result that is not taken.
module quaternion_alu_unit import qalu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  qalu_in_if.sink    in_ch,
  qalu_out_if.source out_ch
);

  logic             en;
  logic [3:0][31:0] a_in, b_in;
  logic             mul_vld, sq_vld;
  qalu_ctl_t        mul_ctl, sq_ctl;
  logic [63:0]      sumsq;
  logic [31:0]      root;
  logic [3:0][31:0] r_out;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign a_in = {in_ch.a_w, in_ch.a_z, in_ch.a_y, in_ch.a_x};
  assign b_in = {in_ch.b_w, in_ch.b_z, in_ch.b_y, in_ch.b_x};

  qalu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_ch.valid),
    .in_op     (op_t'(in_ch.opcode)),
    .in_a      (a_in),
    .in_b      (b_in),
    .in_s      (in_ch.scalar),
    .out_vld   (mul_vld),
    .out_ctl   (mul_ctl),
    .out_sumsq (sumsq)
  );

  qalu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (mul_vld),
    .in_ctl   (mul_ctl),
    .in_sumsq (sumsq),
    .out_vld  (sq_vld),
    .out_ctl  (sq_ctl),
    .out_root (root)
  );

  qalu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .in_ctl  (sq_ctl),
    .in_root (root),
    .out_vld (out_ch.valid),
    .out_r   (r_out),
    .out_mag (out_ch.magnitude),
    .out_eq  (out_ch.is_equal),
    .out_err (out_ch.error)
  );

  assign out_ch.r_x = r_out[0];
  assign out_ch.r_y = r_out[1];
  assign out_ch.r_z = r_out[2];
  assign out_ch.r_w = r_out[3];

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error |->
      out_ch.r_x == 0 && out_ch.r_y == 0 && out_ch.r_z == 0 && out_ch.r_w == 0 &&
      out_ch.magnitude == 0 && !out_ch.is_equal)
    else $error("error result carries nonzero fields");

  a_eq_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_equal |->
      out_ch.magnitude == 0 && !out_ch.error && out_ch.r_x == 0 && out_ch.r_w == 0)
    else $error("compare result carries other fields");

  a_mag_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.magnitude != 0 |->
      out_ch.r_x == 0 && out_ch.r_y == 0 && out_ch.r_z == 0 && out_ch.r_w == 0)
    else $error("length result carries quaternion fields");

endmodule

[sim/quaternion_alu_unit_tb.sv]
// Self-checking testbench for the quaternion ALU: directed and random items, result ordering.
module quaternion_alu_unit_tb;
  import qalu_pkg::*;

  typedef struct {
    logic [31:0] rx, ry, rz, rw, mag;
    logic eq, err;
  } qres_t;

  localparam int FB = 16;
  localparam int WATCH_LIMIT = 20000;

  class qalu_scoreboard;
    qres_t pending[$];
    int fails;

    function new();
      fails = 0;
    endfunction

    function void note_input(qres_t r);
      pending.push_back(r);
    endfunction

    function void check_result(qres_t got);
      qres_t e;
      if (pending.size() == 0) begin
        $error("unexpected result");
        fails++;
        return;
      end
      e = pending.pop_front();
      if (got.rx !== e.rx) begin $error("r_x exp %h got %h", e.rx, got.rx); fails++; end
      if (got.ry !== e.ry) begin $error("r_y exp %h got %h", e.ry, got.ry); fails++; end
      if (got.rz !== e.rz) begin $error("r_z exp %h got %h", e.rz, got.rz); fails++; end
      if (got.rw !== e.rw) begin $error("r_w exp %h got %h", e.rw, got.rw); fails++; end
      if (got.mag !== e.mag) begin
        $error("magnitude exp %h got %h", e.mag, got.mag); fails++;
      end
      if (got.eq !== e.eq) begin $error("is_equal exp %b got %b", e.eq, got.eq); fails++; end
      if (got.err !== e.err) begin $error("error exp %b got %b", e.err, got.err); fails++; end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  always #5 clk = ~clk;

  qalu_in_if in_ch();
  qalu_out_if out_ch();

  quaternion_alu_unit #(.FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  qalu_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int quiet = 0;

  function automatic logic signed [65:0] mul_floor(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 66'(p >>> FB);
  endfunction

  function automatic logic [31:0] clamp32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7fffffff;
    if (v < -66'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] sum_squares(logic signed [31:0] q[4]);
    logic [64:0] s;
    logic [63:0] m;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      m = q[i] < 0 ? 64'(-64'(q[i])) : 64'(q[i]);
      s = s + 65'(m * m);
      if (s[64]) return '1;
    end
    return s[63:0];
  endfunction

  function automatic qres_t quat_predict(op_t op, logic signed [31:0] a[4],
                                        logic signed [31:0] b[4], logic signed [31:0] s);
    qres_t res;
    logic signed [65:0] r[4];
    logic [63:0] len;
    logic signed [65:0] num;
    res = '{default: 0};
    for (int i = 0; i < 4; i++) r[i] = 0;
    case (op)
      OP_QMUL: begin
        r[0] = mul_floor(a[0], b[3]) + mul_floor(a[3], b[0]) + mul_floor(a[1], b[2])
             - mul_floor(a[2], b[1]);
        r[1] = mul_floor(a[1], b[3]) + mul_floor(a[3], b[1]) + mul_floor(a[2], b[0])
             - mul_floor(a[0], b[2]);
        r[2] = mul_floor(a[2], b[3]) + mul_floor(a[3], b[2]) + mul_floor(a[0], b[1])
             - mul_floor(a[1], b[0]);
        r[3] = mul_floor(a[3], b[3]) - mul_floor(a[0], b[0]) - mul_floor(a[1], b[1])
             - mul_floor(a[2], b[2]);
      end
      OP_QMULV: begin
        r[0] = mul_floor(a[3], b[0]) + mul_floor(a[1], b[2]) - mul_floor(a[2], b[1]);
        r[1] = mul_floor(a[3], b[1]) + mul_floor(a[2], b[0]) - mul_floor(a[0], b[2]);
        r[2] = mul_floor(a[3], b[2]) + mul_floor(a[0], b[1]) - mul_floor(a[1], b[0]);
        r[3] = -mul_floor(a[0], b[0]) - mul_floor(a[1], b[1]) - mul_floor(a[2], b[2]);
      end
      OP_SCALE: for (int i = 0; i < 4; i++) r[i] = mul_floor(a[i], s);
      OP_DIV: begin
        if (s == 0) res.err = 1;
        else for (int i = 0; i < 4; i++) begin
          num = 66'(a[i]) <<< FB;
          r[i] = num / 66'(s);
        end
      end
      OP_NORM: begin
        len = root64(sum_squares(a));
        if (len == 0) res.err = 1;
        else for (int i = 0; i < 4; i++) begin
          num = 66'(a[i]) <<< FB;
          r[i] = num / $signed({2'b00, len});
        end
      end
      OP_CONJ: begin
        r[0] = -66'(a[0]);
        r[1] = -66'(a[1]);
        r[2] = -66'(a[2]);
        r[3] = 66'(a[3]);
      end
      OP_LEN: begin
        len = root64(sum_squares(a));
        res.mag = len > 64'hffffffff ? 32'hffffffff : len[31:0];
      end
      default: res.eq = (a[0] == b[0] && a[1] == b[1] && a[2] == b[2] && a[3] == b[3]);
    endcase
    res.rx = clamp32(r[0]);
    res.ry = clamp32(r[1]);
    res.rz = clamp32(r[2]);
    res.rw = clamp32(r[3]);
    return res;
  endfunction

  function automatic logic [31:0] pick_value(int mode);
    case (mode)
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h10000 : 32'hffff0000;
      4: return $urandom();
      default: return 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
    endcase
  endfunction

  task automatic send_item(op_t op, logic [31:0] a[4], logic [31:0] b[4], logic [31:0] s);
    logic signed [31:0] sa[4], sbv[4];
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.a_x <= a[0]; in_ch.a_y <= a[1]; in_ch.a_z <= a[2]; in_ch.a_w <= a[3];
    in_ch.b_x <= b[0]; in_ch.b_y <= b[1]; in_ch.b_z <= b[2]; in_ch.b_w <= b[3];
    in_ch.scalar <= s;
    for (int i = 0; i < 4; i++) begin
      sa[i] = a[i];
      sbv[i] = b[i];
    end
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(quat_predict(op, sa, sbv, s));
  endtask

  task automatic random_item();
    logic [31:0] a[4], b[4], s;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      a[i] = pick_value(mode < 4 ? $urandom_range(0, 5) : (mode < 7 ? 4 : 5));
      b[i] = $urandom_range(0, 3) == 0 ? a[i] : pick_value($urandom_range(0, 5));
    end
    s = pick_value($urandom_range(0, 5));
    send_item(op_t'($urandom_range(0, 7)), a, b, s);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result('{rx: out_ch.r_x, ry: out_ch.r_y, rz: out_ch.r_z, rw: out_ch.r_w,
                        mag: out_ch.magnitude, eq: out_ch.is_equal, err: out_ch.error});
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [31:0] a[4], b[4];
    logic [31:0] ext[4];
    in_ch.valid = 0;
    in_ch.opcode = 0;
    in_ch.a_x = 0; in_ch.a_y = 0; in_ch.a_z = 0; in_ch.a_w = 0;
    in_ch.b_x = 0; in_ch.b_y = 0; in_ch.b_z = 0; in_ch.b_w = 0;
    in_ch.scalar = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    ext = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
    for (int op = 0; op < 8; op++) begin
      send_item(op_t'(op), ext, ext, 32'h80000000);
      send_item(op_t'(op), '{32'h10000, 32'hfffe8000, 32'h3, 32'hffffffff},
                '{32'h20000, 32'h1, 32'h7fffffff, 32'h80000000}, 32'h7fffffff);
    end
    a = '{0, 0, 0, 0};
    b = '{5, 6, 7, 8};
    send_item(OP_DIV, b, a, 32'h0);
    send_item(OP_NORM, a, b, 32'h1);
    send_item(OP_LEN, a, b, 32'h1);
    send_item(OP_CMP, b, b, 32'h0);
    send_item(OP_CONJ, '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000}, b, 0);
    send_item(OP_DIV, ext, b, 32'h1);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 27 : (ph == 1 ? 83 : 0);
      recv_idle = ph == 0 ? 83 : (ph == 1 ? 27 : 0);
      repeat (650) random_item();
    end
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
